// ----- rtl/core/obst_pkg.sv -----
`timescale 1ns / 1ps
package obst_pkg;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_CANCEL = 3'd1,
    OP_MODIFY = 3'd2,
    OP_ERASE  = 3'd3,
    OP_UPDATE = 3'd4,
    OP_READ   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_DUP     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_INSERT,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic insert;
  } dp_cmd_t;

  typedef struct packed {
    logic reinsert;
  } dp_sts_t;

endpackage

// ----- rtl/core/obst_ctrl.sv -----
`timescale 1ns / 1ps
module obst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  obst_pkg::dp_sts_t sts,
  output obst_pkg::dp_cmd_t cmd,
  output logic              busy,
  output logic              done
);
  import obst_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = sts.reinsert ? S_INSERT : S_DONE;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/obst_dp.sv -----
`timescale 1ns / 1ps
module obst_dp #(
  parameter int DEPTH = 64,
  parameter int PRICE_BITS = 32,
  parameter int CW = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  obst_pkg::dp_cmd_t cmd,
  output obst_pkg::dp_sts_t sts,
  input  logic [2:0]        operation,
  input  logic [63:0]       order_id,
  input  logic [31:0]       price,
  input  logic [31:0]       volume,
  input  logic [5:0]        position,
  output logic [1:0]        status,
  output logic [CW-1:0]     entry_count,
  output logic              best_valid,
  output logic [31:0]       best_price,
  output logic [31:0]       best_volume,
  output logic [63:0]       read_id,
  output logic [31:0]       read_price,
  output logic [31:0]       read_volume
);
  import obst_pkg::*;

  localparam int PW = PRICE_BITS;
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMPW = CW + 6;

  // Book cells: entry 0 is the best price.
  logic [63:0]   cid   [DEPTH];
  logic [PW-1:0] cprice[DEPTH];
  logic [31:0]   cvol  [DEPTH];
  logic [CW-1:0] count;

  op_t           op_q;
  logic [63:0]   id_q;
  logic [PW-1:0] price_q;
  logic [31:0]   vol_q;
  logic [5:0]    pos_q;
  status_t       status_q;
  logic [63:0]   rid_q;
  logic [31:0]   rprice_q, rvol_q;

  logic [DEPTH-1:0] live, match, ge, gp, mk, pk, rm, upd;
  logic             found, pos_ok, do_insert, do_remove, reinsert;
  logic [31:0]      vk;
  logic [PW-1:0]    prk;
  status_t          st;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      live[i]  = CW'(i) < count;
      match[i] = live[i] && (cid[i] == id_q);
      ge[i]    = live[i] && (cprice[i] >= price_q);
      pk[i]    = CMPW'(i) >= CMPW'(pos_q);
    end
    gp[0] = 1'b1;
    mk[0] = match[0];
    for (int i = 1; i < DEPTH; i++) begin
      gp[i] = ge[i-1];
      mk[i] = mk[i-1] | match[i];
    end
    found = |match;
    // Ids are unique in the book, so an OR over the matching cell selects it.
    vk  = '0;
    prk = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i]) begin
        vk  = vk | cvol[i];
        prk = prk | cprice[i];
      end
    end
    pos_ok = CMPW'(pos_q) < CMPW'(count);

    st = ST_OK;
    do_insert = 1'b0;
    do_remove = 1'b0;
    reinsert = 1'b0;
    rm = '0;
    upd = '0;
    case (op_q)
      OP_ADD: begin
        if (found) st = ST_DUP;
        else if (count == CW'(DEPTH)) st = ST_FULL;
        else do_insert = 1'b1;
      end
      OP_CANCEL: begin
        if (!found) st = ST_MISSING;
        else begin
          do_remove = 1'b1;
          rm = mk;
        end
      end
      OP_MODIFY: begin
        if (!found) st = ST_MISSING;
        else if (vol_q > vk || price_q != prk) begin
          do_remove = 1'b1;
          rm = mk;
          reinsert = 1'b1;
        end else begin
          upd = match;
        end
      end
      OP_ERASE: begin
        if (!pos_ok) st = ST_MISSING;
        else begin
          do_remove = 1'b1;
          rm = pk;
        end
      end
      OP_UPDATE: begin
        if (!pos_ok) st = ST_MISSING;
        else upd = pk & ~(pk << 1);
      end
      OP_READ: begin
        if (!pos_ok) st = ST_MISSING;
      end
      default: st = ST_OK;
    endcase
    if (!cmd.exec) begin
      do_insert = cmd.insert;
      do_remove = 1'b0;
      upd = '0;
    end
    sts.reinsert = reinsert;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= op_t'(operation);
      id_q    <= order_id;
      price_q <= PW'(price);
      vol_q   <= volume;
      pos_q   <= position;
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (do_insert && !ge[i]) begin
        if (gp[i]) begin
          cid[i]    <= id_q;
          cprice[i] <= price_q;
          cvol[i]   <= vol_q;
        end else if (i > 0) begin
          cid[i]    <= cid[i-1];
          cprice[i] <= cprice[i-1];
          cvol[i]   <= cvol[i-1];
        end
      end else if (do_remove && rm[i] && i + 1 < DEPTH) begin
        cid[i]    <= cid[i+1];
        cprice[i] <= cprice[i+1];
        cvol[i]   <= cvol[i+1];
      end else if (upd[i]) begin
        cvol[i] <= vol_q;
      end
    end
    if (cmd.exec) begin
      status_q <= st;
      rid_q    <= '0;
      rprice_q <= '0;
      rvol_q   <= '0;
      if (op_q == OP_READ && pos_ok) begin
        rid_q    <= cid[IW'(pos_q)];
        rprice_q <= 32'(cprice[IW'(pos_q)]);
        rvol_q   <= cvol[IW'(pos_q)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_insert) begin
      count <= count + CW'(1);
    end else if (do_remove) begin
      count <= count - CW'(1);
    end
  end

  assign status      = status_q;
  assign entry_count = count;
  assign best_valid  = count != '0;
  assign best_price  = best_valid ? 32'(cprice[0]) : '0;
  assign best_volume = best_valid ? cvol[0] : '0;
  assign read_id     = rid_q;
  assign read_price  = rprice_q;
  assign read_volume = rvol_q;

endmodule

// ----- rtl/core/order_book_side_table.sv -----
`timescale 1ns / 1ps
// One side of a limit order book, up to DEPTH orders kept in descending
// price order, first come first served within a price.
// Input channel: an item (operation, order_id, price, volume, position) is
// accepted at a clock edge where start is high and busy is low. The block
// then raises busy until the item's result has been shown.
// Output channel: one result per item, valid for exactly one cycle while
// done is high. The receiver cannot stall; it must take the result then.
// A result passes through the states EXEC and DONE; a modify that moves
// the order also passes through INSERT, because its removal and its
// re-insertion each take one shift of the register row.
// A new item can be accepted the cycle after done, so the block takes no
// new item while it is still busy with the last one.
// Every cell compares its id and price in parallel; one shift moves the row.
// Reset (rst, synchronous) empties the book and returns to idle at once.
// Entry contents are not cleared; only entries below the count are ever seen.
module order_book_side_table #(
  parameter int DEPTH = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  output logic                         done,
  input  logic [2:0]                   operation,
  input  logic [63:0]                  order_id,
  input  logic [31:0]                  price,
  input  logic [31:0]                  volume,
  input  logic [5:0]                   position,
  output logic [1:0]                   status,
  output logic [$clog2(DEPTH+1)-1:0]   entry_count,
  output logic                         best_valid,
  output logic [31:0]                  best_price,
  output logic [31:0]                  best_volume,
  output logic [63:0]                  read_id,
  output logic [31:0]                  read_price,
  output logic [31:0]                  read_volume
);
  import obst_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  dp_cmd_t cmd;
  dp_sts_t sts;

  obst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  obst_dp #(
    .DEPTH      (DEPTH),
    .PRICE_BITS (PRICE_BITS),
    .CW         (CW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .operation   (operation),
    .order_id    (order_id),
    .price       (price),
    .volume      (volume),
    .position    (position),
    .status      (status),
    .entry_count (entry_count),
    .best_valid  (best_valid),
    .best_price  (best_price),
    .best_volume (best_volume),
    .read_id     (read_id),
    .read_price  (read_price),
    .read_volume (read_volume)
  );

endmodule

// ----- rtl/core/obst_checker.sv -----
`timescale 1ns / 1ps
module obst_checker #(
  parameter int DEPTH = 64
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic [$clog2(DEPTH+1)-1:0] entry_count,
  input logic                       best_valid
);

  // An accepted item makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // A result is only shown while the item is still in flight.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside of busy");

  // The block is free right after a result.
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("block not free after result");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> entry_count <= DEPTH && best_valid == (entry_count != 0))
    else $error("count or best flag inconsistent");

endmodule

bind order_book_side_table obst_checker #(.DEPTH(DEPTH)) u_obst_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .entry_count (entry_count),
  .best_valid  (best_valid)
);
